@@ rtl/ftdf_pkg.sv @@
// ftdf_pkg: shared types and constants for the flow tuple dedup filter
// no dependencies
`default_nettype none
package ftdf_pkg;
  localparam logic [31:0] FNV_SEED  = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  localparam int V6_BYTES = 38;
  localparam int V4_BYTES = 10;
  localparam int V6_ENTRY_W = 64 * 4 + 16 * 2 + 32;
  localparam int V4_ENTRY_W = 32 * 2 + 16 * 2 + 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_WRITE
  } state_t;
endpackage
`default_nettype wire

@@ rtl/ftdf_ram.sv @@
// ftdf_ram: generic single-port RAM with registered read
// no dependencies
`default_nettype none
module ftdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] addr,
  input  wire  [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/ftdf_hash.sv @@
// ftdf_hash: byte-serial fnv-1a unit, one byte per cycle while step is high, over a shift register
// depends on ftdf_pkg
`default_nettype none
module ftdf_hash (
  input  wire                                 clk,
  input  wire                                 load,
  input  wire  [ftdf_pkg::V6_BYTES*8-1:0]     bytes_in,
  input  wire                                 step,
  output logic [31:0]                         hash
);
  import ftdf_pkg::*;

  logic [V6_BYTES*8-1:0] sh_r;
  logic [31:0]           h_r;
  logic [31:0]           mixed;

  assign mixed = h_r ^ {24'd0, sh_r[7:0]};
  assign hash  = h_r;

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r <= bytes_in;
      h_r  <= FNV_SEED;
    end else if (step) begin
      sh_r <= {8'd0, sh_r[V6_BYTES*8-1:8]};
      h_r  <= mixed * FNV_PRIME;
    end
  end
endmodule
`default_nettype wire

@@ rtl/flow_tuple_dedup_filter_core.sv @@
// flow_tuple_dedup_filter_core: fnv-1a hashed set-associative dedup cache
// depends on ftdf_pkg, ftdf_hash, ftdf_ram
//
// One tuple per command. The hash runs one byte a cycle in a shared fnv-1a
// unit (10 bytes for IPv4, 38 for IPv6), then the bucket index is latched;
// the bucket then takes a read issue state, a compare state and a write
// state, since all ways of a bucket sit side by side in one wide memory word
// per table. out_valid is registered and rises after the write state; busy
// is high until the out_valid cycle, so the next item can be taken at the
// edge that ends it, and no new item is taken before the last is through.
// After reset the tables are cleared one bucket per cycle, BUCKETS rounded up
// to a power of two buckets in all, with busy high. out_valid pulses for one
// cycle and cannot be held off.
`default_nettype none
module flow_tuple_dedup_filter_core #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_is_ipv6,
  input  wire  [63:0] in_remote_addr_hi,
  input  wire  [63:0] in_remote_addr_lo,
  input  wire  [15:0] in_remote_port,
  input  wire  [63:0] in_local_addr_hi,
  input  wire  [63:0] in_local_addr_lo,
  input  wire  [15:0] in_local_port,
  input  wire  [31:0] in_response_type,
  output logic        out_valid,
  output logic        out_duplicate
);
  import ftdf_pkg::*;

  localparam int AW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WIW = $clog2(WAYS);
  localparam int CW  = $clog2(V6_BYTES + 1);

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          v6_r;
  logic [V6_ENTRY_W-1:0] key6_r;
  logic [V4_ENTRY_W-1:0] key4_r;
  logic [AW-1:0] idx_r;
  logic          dup_r, dup_nxt;
  logic [WIW-1:0] hitw_r, hitw_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [V6_BYTES*8-1:0] hbytes;
  logic [31:0] hash;
  logic load, step;

  logic [V6_ENTRY_W*WAYS-1:0] rd6, wd6;
  logic [V4_ENTRY_W*WAYS-1:0] rd4, wd4;
  logic we6, we4;
  logic [AW-1:0] addr;
  logic [V6_ENTRY_W*WAYS-1:0] rd6_r;
  logic [V4_ENTRY_W*WAYS-1:0] rd4_r;

  // little-endian byte streams, first byte hashed in the low bits
  always_comb begin
    if (in_is_ipv6) begin
      hbytes = {in_response_type[15:0], in_local_port, in_local_addr_lo,
                in_local_addr_hi, in_remote_port, in_remote_addr_lo,
                in_remote_addr_hi};
    end else begin
      hbytes = {224'd0, in_response_type[15:0], in_local_port,
                in_local_addr_lo[15:0], in_remote_port, in_remote_addr_lo[15:0]};
    end
  end

  ftdf_hash u_hash (
    .clk(clk), .load(load), .bytes_in(hbytes), .step(step), .hash(hash)
  );

  ftdf_ram #(.WIDTH(V6_ENTRY_W*WAYS), .DEPTH(1 << AW)) u_ram6 (
    .clk(clk), .we(we6), .addr(addr), .wdata(wd6), .rdata(rd6)
  );
  ftdf_ram #(.WIDTH(V4_ENTRY_W*WAYS), .DEPTH(1 << AW)) u_ram4 (
    .clk(clk), .we(we4), .addr(addr), .wdata(wd4), .rdata(rd4)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v6_r   <= in_is_ipv6;
      key6_r <= {in_remote_addr_hi, in_remote_addr_lo, in_local_addr_hi,
                 in_local_addr_lo, in_remote_port, in_local_port, in_response_type};
      key4_r <= {in_remote_addr_lo[31:0], in_local_addr_lo[31:0], in_remote_port,
                 in_local_port, in_response_type};
    end
    if (state_r == ST_HASH && cnt_r == '0) begin
      idx_r <= hash[AW-1:0] & AW'(BUCKETS - 1);
    end
    if (state_r == ST_CMP) begin
      rd6_r <= rd6;
      rd4_r <= rd4;
    end
    dup_r  <= dup_nxt;
    hitw_r <= hitw_nxt;
  end

  // way compare on freshly read bucket
  always_comb begin
    dup_nxt  = dup_r;
    hitw_nxt = hitw_r;
    if (state_r == ST_CMP) begin
      dup_nxt  = 1'b0;
      hitw_nxt = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (v6_r ? (rd6[w*V6_ENTRY_W +: V6_ENTRY_W] == key6_r)
                 : (rd4[w*V4_ENTRY_W +: V4_ENTRY_W] == key4_r)) begin
          dup_nxt  = 1'b1;
          hitw_nxt = WIW'(w);
        end
      end
    end
  end

  // bucket update: zero on clear, swap hit way to way 0, or shift down and insert
  always_comb begin
    wd6 = rd6_r;
    wd4 = rd4_r;
    if (state_r == ST_CLEAR) begin
      wd6 = '0;
      wd4 = '0;
    end else if (dup_r) begin
      wd6[0 +: V6_ENTRY_W] = rd6_r[hitw_r*V6_ENTRY_W +: V6_ENTRY_W];
      wd6[hitw_r*V6_ENTRY_W +: V6_ENTRY_W] = rd6_r[0 +: V6_ENTRY_W];
      wd4[0 +: V4_ENTRY_W] = rd4_r[hitw_r*V4_ENTRY_W +: V4_ENTRY_W];
      wd4[hitw_r*V4_ENTRY_W +: V4_ENTRY_W] = rd4_r[0 +: V4_ENTRY_W];
    end else begin
      wd6 = {rd6_r[V6_ENTRY_W*(WAYS-1)-1:0], key6_r};
      wd4 = {rd4_r[V4_ENTRY_W*(WAYS-1)-1:0], key4_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    load          = 1'b0;
    step          = 1'b0;
    we6           = 1'b0;
    we4           = 1'b0;
    addr          = idx_r;
    busy          = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        addr = clr_r;
        we6  = 1'b1;
        we4  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'((1 << AW) - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          load      = 1'b1;
          cnt_nxt   = in_is_ipv6 ? CW'(V6_BYTES) : CW'(V4_BYTES);
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (cnt_r == '0) begin
          state_nxt = ST_READ;
        end else begin
          step    = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        we6 = v6_r;
        we4 = !v6_r;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_duplicate = dup_r;
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking testbench for flow_tuple_dedup_filter_core
// depends on ftdf_pkg and the core; predicts duplicate flags with its own cache model
`default_nettype none

module tb;
  typedef struct packed {
    logic [63:0] rh, rl, lh, ll;
    logic [15:0] rp, lp;
    logic [31:0] ty;
  } tuple_t;

  class dedup_scoreboard;
    localparam int NBKT = 1024;
    localparam int NWAY = 4;

    tuple_t v4_tab[NBKT * NWAY];
    tuple_t v6_tab[NBKT * NWAY];
    bit dup_q[$];
    int errors;

    function new();
      tuple_t z;
      z = '0;
      foreach (v4_tab[i]) v4_tab[i] = z;
      foreach (v6_tab[i]) v6_tab[i] = z;
      errors = 0;
    endfunction

    function automatic logic [31:0] fnv_bytes(logic [31:0] h, logic [63:0] v, int n);
      for (int k = 0; k < n; k++) h = (h ^ {24'd0, v[8*k +: 8]}) * ftdf_pkg::FNV_PRIME;
      return h;
    endfunction

    function void note_tuple(bit v6, tuple_t t);
      logic [31:0] h;
      int base;
      bit hit;
      tuple_t tmp;
      h = ftdf_pkg::FNV_SEED;
      if (v6) begin
        h = fnv_bytes(h, t.rh, 8);
        h = fnv_bytes(h, t.rl, 8);
        h = fnv_bytes(h, {48'd0, t.rp}, 2);
        h = fnv_bytes(h, t.lh, 8);
        h = fnv_bytes(h, t.ll, 8);
        h = fnv_bytes(h, {48'd0, t.lp}, 2);
        h = fnv_bytes(h, {32'd0, t.ty}, 2);
      end else begin
        t.rh = '0;
        t.lh = '0;
        t.rl = {32'd0, t.rl[31:0]};
        t.ll = {32'd0, t.ll[31:0]};
        h = fnv_bytes(h, t.rl, 2);
        h = fnv_bytes(h, {48'd0, t.rp}, 2);
        h = fnv_bytes(h, t.ll, 2);
        h = fnv_bytes(h, {48'd0, t.lp}, 2);
        h = fnv_bytes(h, {32'd0, t.ty}, 2);
      end
      base = int'(h & (NBKT - 1)) * NWAY;
      hit = 0;
      for (int w = 0; w < NWAY && !hit; w++) begin
        tmp = v6 ? v6_tab[base + w] : v4_tab[base + w];
        if (tmp == t) begin
          hit = 1;
          if (v6) begin
            v6_tab[base + w] = v6_tab[base];
            v6_tab[base] = tmp;
          end else begin
            v4_tab[base + w] = v4_tab[base];
            v4_tab[base] = tmp;
          end
        end
      end
      if (!hit) begin
        for (int w = NWAY - 1; w > 0; w--) begin
          if (v6) v6_tab[base + w] = v6_tab[base + w - 1];
          else v4_tab[base + w] = v4_tab[base + w - 1];
        end
        if (v6) v6_tab[base] = t;
        else v4_tab[base] = t;
      end
      dup_q.push_back(hit);
    endfunction

    function void check_beat(bit got);
      if (dup_q.size() == 0) begin
        report_err($sformatf("unexpected beat dup=%0d", got));
        return;
      end
      if (dup_q[0] !== got)
        report_err($sformatf("duplicate got %0d want %0d", got, dup_q[0]));
      void'(dup_q.pop_front());
    endfunction

    function void report_err(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction
  endclass

  logic clk, rst_n, start;
  logic in_is_ipv6;
  logic [63:0] in_remote_addr_hi, in_remote_addr_lo, in_local_addr_hi, in_local_addr_lo;
  logic [15:0] in_remote_port, in_local_port;
  logic [31:0] in_response_type;
  wire busy, out_valid, out_duplicate;

  dedup_scoreboard sb;
  int idle_cnt;
  tuple_t pool[$];

  flow_tuple_dedup_filter_core dut (
    .clk, .rst_n, .start, .busy, .in_is_ipv6,
    .in_remote_addr_hi, .in_remote_addr_lo, .in_remote_port,
    .in_local_addr_hi, .in_local_addr_lo, .in_local_port, .in_response_type,
    .out_valid, .out_duplicate
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    start = 0; in_is_ipv6 = 0;
    in_remote_addr_hi = '0; in_remote_addr_lo = '0; in_local_addr_hi = '0;
    in_local_addr_lo = '0; in_remote_port = '0; in_local_port = '0; in_response_type = '0;
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_beat(out_duplicate);
      if (out_valid || (start && !busy)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 20000) begin
        $display("TB_ERROR");
        $finish;
      end
    end else idle_cnt <= 0;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic tuple_t rnd_tuple();
    tuple_t t;
    t.rh = rnd64(); t.rl = rnd64(); t.lh = rnd64(); t.ll = rnd64();
    t.rp = 16'($urandom); t.lp = 16'($urandom); t.ty = $urandom;
    case ($urandom_range(0, 7))
      0: t.rp = 16'hFFFF;
      1: t.ty = 32'hFFFF_FFFF;
      2: t.rl = '1;
      default: ;
    endcase
    return t;
  endfunction

  // start stays high across back-to-back beats; it drops only for a gap or in drain
  task automatic send_tuple(bit v6, tuple_t t);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1; in_is_ipv6 <= v6;
    in_remote_addr_hi <= t.rh; in_remote_addr_lo <= t.rl; in_remote_port <= t.rp;
    in_local_addr_hi <= t.lh; in_local_addr_lo <= t.ll; in_local_port <= t.lp;
    in_response_type <= t.ty;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_tuple(v6, t);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.dup_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    tuple_t t;
    bit v6;
    sb = new();
    idle_cnt = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: all-zero tuples, extremes, upper ipv4 bits, way reorder
    t = '0;
    send_tuple(0, t);
    send_tuple(1, t);
    t = '1;
    send_tuple(0, t);
    send_tuple(1, t);
    send_tuple(0, t);
    send_tuple(1, t);
    t = '0; t.rl = 64'hFFFF_FFFF_0000_0000; t.rh = '1; t.lh = '1;
    send_tuple(0, t);
    t.ll = 64'h0000_0001_0000_0000;
    send_tuple(0, t);
    t = '0; t.rl = 64'h0001_0000; t.ty = 32'h0001_0000;
    send_tuple(0, t);
    send_tuple(0, t);
    for (int i = 0; i < 6; i++) begin
      t = rnd_tuple();
      pool.push_back(t);
      send_tuple(i[0], t);
    end
    for (int i = 5; i >= 0; i--) send_tuple(i[0], pool[i]);
    drain();

    // random: mostly revisits of a small working set
    for (int i = 0; i < 2000; i++) begin
      v6 = 1'($urandom_range(0, 1));
      if (pool.size() > 0 && $urandom_range(0, 2) != 0) begin
        t = pool[$urandom_range(0, pool.size() - 1)];
        if (!v6 && $urandom_range(0, 3) == 0) begin
          t.rh = rnd64(); t.rl[63:32] = $urandom;
        end
      end else begin
        t = rnd_tuple();
        if (pool.size() < 64) pool.push_back(t);
        else pool[$urandom_range(0, 63)] = t;
      end
      send_tuple(v6, t);
      if (i == 1000) drain();
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/ftdf_pkg.sv
rtl/ftdf_ram.sv
rtl/ftdf_hash.sv
rtl/flow_tuple_dedup_filter_core.sv
dv/tb.sv
